FILE: rtl/cpd_pkg.sv
// Shared types, constants and the CRC-8 update function for the packet deframer.
// No dependencies.
package cpd_pkg;

  localparam int unsigned MaxPayload = 1024;
  localparam int unsigned AddrW      = $clog2(MaxPayload);

  localparam logic [7:0] CrcPoly = 8'h8C;

  localparam logic [1:0] MODE_RECV    = 2'd0;
  localparam logic [1:0] MODE_READ    = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;

  localparam logic REG_HEADER_FIRST  = 1'b0;
  localparam logic REG_HEADER_SECOND = 1'b1;

  localparam logic [7:0] HeaderFirstRst  = 8'hAA;
  localparam logic [7:0] HeaderSecondRst = 8'h55;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] byte_value;
    logic [9:0] read_index;
  } cpd_in_t;

  typedef struct packed {
    logic        packet_ready;
    logic [10:0] packet_size;
    logic [7:0]  read_data;
    logic [7:0]  crc_value;
    logic        crc_match;
  } cpd_out_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } cpd_wr_t;

  typedef struct packed {
    logic        packet_ready;
    logic [10:0] packet_size;
    logic [7:0]  crc_value;
    logic        crc_match;
  } cpd_status_t;

  // reflected CRC-8, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/cpd_payload_ram.sv
// Payload buffer: one write port, one read port with registered read data.
// Depends on cpd_pkg.
module cpd_payload_ram
  import cpd_pkg::*;
(
  input  logic             clk_i,
  input  cpd_wr_t          wr_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o
);

  logic [7:0] mem [MaxPayload];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/cpd_parser.sv
// Frame parser: header match, length capture, payload count, running CRC and
// header configuration registers. Depends on cpd_pkg.
module cpd_parser
  import cpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        accept_i,
  input  cpd_in_t     item_i,
  output cpd_wr_t     wr_o,
  output cpd_status_t status_o
);

  typedef enum logic [2:0] {
    ST_HDR0  = 3'd0,
    ST_HDR1  = 3'd1,
    ST_LEN0  = 3'd2,
    ST_LEN1  = 3'd3,
    ST_PAY   = 3'd4,
    ST_CRC   = 3'd5,
    ST_READY = 3'd6
  } state_e;

  state_e      state_q, state_d;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] exp_len_q, exp_len_d;
  logic [10:0] len_q, len_d;
  logic [7:0]  rx_crc_q, rx_crc_d;
  logic [7:0]  hdr_first_q, hdr_second_q;
  logic [7:0]  crc_feed;
  logic [15:0] len_full;
  logic [10:0] len_inc;
  logic [7:0]  b;

  assign b        = item_i.byte_value;
  assign crc_feed = crc8_byte(crc_q, b);
  assign len_full = {exp_len_q[15:8], b};
  assign len_inc  = len_q + 11'd1;

  always_comb begin
    state_d   = state_q;
    crc_d     = crc_q;
    exp_len_d = exp_len_q;
    len_d     = len_q;
    rx_crc_d  = rx_crc_q;
    wr_o.en   = 1'b0;
    wr_o.addr = len_q[AddrW-1:0];
    wr_o.data = b;
    if (accept_i) begin
      case (item_i.mode)
        MODE_RECV: begin
          case (state_q)
            ST_HDR0, ST_READY: begin
              if (b == hdr_first_q) begin
                state_d = ST_HDR1;
                len_d   = '0;
                crc_d   = crc8_byte(8'h00, b);
              end
            end
            ST_HDR1: begin
              if (b == hdr_second_q) begin
                state_d = ST_LEN0;
                crc_d   = crc_feed;
              end else begin
                state_d = ST_HDR0;
                crc_d   = '0;
                len_d   = '0;
              end
            end
            ST_LEN0: begin
              state_d   = ST_LEN1;
              exp_len_d = {b, 8'h00};
              crc_d     = crc_feed;
            end
            ST_LEN1: begin
              exp_len_d = len_full;
              if (len_full >= 16'(MaxPayload)) begin
                state_d = ST_HDR0;
                crc_d   = '0;
                len_d   = '0;
              end else begin
                state_d = ST_PAY;
                crc_d   = crc_feed;
              end
            end
            ST_PAY: begin
              wr_o.en = 1'b1;
              len_d   = len_inc;
              crc_d   = crc_feed;
              if (16'(len_inc) >= exp_len_q) begin
                state_d = ST_CRC;
              end
            end
            ST_CRC: begin
              rx_crc_d = b;
              state_d  = ST_READY;
            end
            default: begin
              state_d = ST_HDR0;
              crc_d   = '0;
              len_d   = '0;
            end
          endcase
        end
        MODE_RELEASE: begin
          if (state_q == ST_READY) begin
            state_d = ST_HDR0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_HDR0;
      crc_q        <= '0;
      exp_len_q    <= '0;
      len_q        <= '0;
      rx_crc_q     <= '0;
      hdr_first_q  <= HeaderFirstRst;
      hdr_second_q <= HeaderSecondRst;
    end else begin
      state_q   <= state_d;
      crc_q     <= crc_d;
      exp_len_q <= exp_len_d;
      len_q     <= len_d;
      rx_crc_q  <= rx_crc_d;
      if (cfg_we_i && cfg_idx_i == REG_HEADER_FIRST) begin
        hdr_first_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == REG_HEADER_SECOND) begin
        hdr_second_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    status_o.packet_ready = (state_q == ST_READY);
    status_o.packet_size  = status_o.packet_ready ? len_q : '0;
    status_o.crc_value    = crc_q;
    status_o.crc_match    = status_o.packet_ready && (rx_crc_q == crc_q);
  end

endmodule

FILE: rtl/crc8_packet_deframer_unit.sv
// Top level of the CRC-8 packet deframer: handshake, parser and payload buffer.
// Depends on cpd_pkg, cpd_parser, cpd_payload_ram.
//
//   channel  | handshake            | payload
//   in       | in_valid_i/in_ready_o   | in_item_i (cpd_in_t)
//   out      | out_valid_o/out_ready_i | out_item_o (cpd_out_t)
//   cfg      | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// One item per cycle while in_ready_o is high; its result is valid in the cycle after acceptance.
// The parser state registers and the buffer read register hold the result.
// in_ready_o drops only while a result is held and out_ready_i is low.
// Reset clears parser state and restores header values; the buffer is not cleared.
module crc8_packet_deframer_unit
  import cpd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  cpd_in_t    in_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output cpd_out_t   out_item_o
);

  logic        out_valid_q;
  logic        rd_sel_q;
  logic        accept;
  logic        rd_en;
  cpd_wr_t     wr;
  cpd_status_t status;
  logic [7:0]  rd_data;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign rd_en      = accept && (in_item_i.mode == MODE_READ);

  cpd_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .wr_o       (wr),
    .status_o   (status)
  );

  cpd_payload_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (in_item_i.read_index[AddrW-1:0]),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rd_sel_q    <= 1'b0;
    end else begin
      if (accept) begin
        out_valid_q <= 1'b1;
        rd_sel_q    <= (in_item_i.mode == MODE_READ);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o             = out_valid_q;
  assign out_item_o.packet_ready = status.packet_ready;
  assign out_item_o.packet_size  = status.packet_size;
  assign out_item_o.read_data    = rd_sel_q ? rd_data : 8'h00;
  assign out_item_o.crc_value    = status.crc_value;
  assign out_item_o.crc_match    = status.crc_match;

endmodule

FILE: rtl/cpd_checker.sv
// Port-level checks for the packet deframer, bound to the top level.
// Depends on cpd_pkg and crc8_packet_deframer_unit.
module cpd_checker
  import cpd_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input cpd_in_t  in_item_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input cpd_out_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted item produced no result");

  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.mode == MODE_RELEASE
    |=> !out_item_o.packet_ready)
    else $error("packet still ready after release");

  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.mode != MODE_READ
    |=> out_item_o.read_data == 8'h00)
    else $error("read data nonzero for non-read item");

  a_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.packet_ready
    |-> out_item_o.packet_size == 11'd0 && !out_item_o.crc_match)
    else $error("size or match reported without a ready packet");

endmodule

bind crc8_packet_deframer_unit cpd_checker u_cpd_checker (.*);

FILE: dv/tb_top.sv
// Self-checking testbench for crc8_packet_deframer_unit: directed table, then random
// frames, noise and broken frames under several header settings, checked item by item.
// Depends on cpd_pkg and the RTL of the deframer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cpd_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned HOLD_CYCLES = 90;
  localparam int unsigned WATCHDOG = 1500;
  localparam int unsigned ITEMS_PER_SETTING = 95;
  localparam int unsigned LONG_FRAME_LEN = 96;
  localparam int unsigned MAX_REPORTS = 50;

  typedef enum logic [2:0] {
    P_HDR0, P_HDR1, P_LEN0, P_LEN1, P_PAY, P_CRC, P_READY
  } parse_e;

  typedef struct {
    logic [1:0] mode;
    logic [7:0] b;
    logic [9:0] idx;
    bit         zero_res;
  } dir_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     cfg_we;
  logic     cfg_idx;
  logic [7:0] cfg_data;
  logic     in_valid;
  logic     in_ready;
  cpd_in_t  in_item;
  logic     out_valid;
  logic     out_ready;
  cpd_out_t out_item;

  crc8_packet_deframer_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  // deframer shadow state
  logic [7:0]  hdr_a, hdr_b, crc_run, rx_crc;
  parse_e      pst;
  logic [15:0] exp_len;
  int unsigned got_len, filled;
  logic [7:0]  store [MaxPayload];

  cpd_out_t    exp_q[$];
  int unsigned n_items, n_results, n_packets, n_crc_ok, n_reads, n_settings;
  int unsigned errors, burst_left, idle_cycles;
  bit          hold_req;

  string fname[5] = '{"packet_ready", "packet_size", "read_data", "crc_value", "crc_match"};

  // rows marked zero_res must leave every output field at zero
  dir_row_t dir_tab[25] = '{
    '{MODE_RELEASE, 8'h00, 10'h000, 1'b1},
    '{MODE_RECV, 8'h00, 10'h000, 1'b1},
    '{MODE_UNUSED, 8'hFF, 10'h3FF, 1'b1},
    '{MODE_RECV, HeaderFirstRst, 10'h000, 1'b0},
    '{MODE_RECV, 8'h12, 10'h000, 1'b1},
    '{MODE_RECV, HeaderFirstRst, 10'h000, 1'b0},
    '{MODE_RECV, HeaderSecondRst, 10'h000, 1'b0},
    '{MODE_RECV, 8'h00, 10'h000, 1'b0},
    '{MODE_RECV, 8'h00, 10'h000, 1'b0},
    '{MODE_RECV, 8'hFF, 10'h000, 1'b0},
    '{MODE_RECV, 8'h00, 10'h000, 1'b0},
    '{MODE_READ, 8'h00, 10'h000, 1'b0},
    '{MODE_RECV, 8'h00, 10'h000, 1'b0},
    '{MODE_RECV, HeaderFirstRst, 10'h000, 1'b0},
    '{MODE_RECV, HeaderSecondRst, 10'h000, 1'b0},
    '{MODE_RECV, 8'h04, 10'h000, 1'b0},
    '{MODE_RECV, 8'h00, 10'h000, 1'b1},
    '{MODE_RECV, HeaderFirstRst, 10'h000, 1'b0},
    '{MODE_RECV, HeaderSecondRst, 10'h000, 1'b0},
    '{MODE_RECV, 8'h00, 10'h000, 1'b0},
    '{MODE_RECV, 8'h01, 10'h000, 1'b0},
    '{MODE_RECV, 8'h7E, 10'h000, 1'b0},
    '{MODE_RECV, 8'hFF, 10'h000, 1'b0},
    '{MODE_RELEASE, 8'h00, 10'h000, 1'b0},
    '{MODE_RELEASE, 8'h00, 10'h000, 1'b0}
  };

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [7:0] crc_step(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] x;
    logic       lsb;
    x = c ^ b;
    repeat (8) begin
      lsb = x[0];
      x = x >> 1;
      if (lsb) x = x ^ CrcPoly;
    end
    return x;
  endfunction

  function automatic cpd_in_t mk_item(input logic [1:0] m, input logic [7:0] b,
                                      input logic [9:0] i);
    cpd_in_t it;
    it.mode = m;
    it.byte_value = b;
    it.read_index = i;
    return it;
  endfunction

  task automatic predict(input cpd_in_t it, output cpd_out_t r);
    logic [7:0] rd;
    logic [7:0] b;
    bit         was_ready;
    rd = '0;
    b = it.byte_value;
    was_ready = (pst == P_READY);
    case (it.mode)
      MODE_RECV: begin
        case (pst)
          P_HDR0, P_READY: begin
            if (b == hdr_a) begin
              got_len = 0;
              crc_run = crc_step(8'h00, b);
              pst = P_HDR1;
            end
          end
          P_HDR1: begin
            if (b == hdr_b) begin
              crc_run = crc_step(crc_run, b);
              pst = P_LEN0;
            end else begin
              crc_run = '0;
              got_len = 0;
              pst = P_HDR0;
            end
          end
          P_LEN0: begin
            exp_len = {b, 8'h00};
            crc_run = crc_step(crc_run, b);
            pst = P_LEN1;
          end
          P_LEN1: begin
            exp_len[7:0] = b;
            crc_run = crc_step(crc_run, b);
            pst = P_PAY;
            if (exp_len >= MaxPayload) begin
              crc_run = '0;
              got_len = 0;
              pst = P_HDR0;
            end
          end
          P_PAY: begin
            if (got_len < MaxPayload) begin
              store[got_len] = b;
              if (got_len + 1 > filled) filled = got_len + 1;
            end
            got_len++;
            crc_run = crc_step(crc_run, b);
            if (got_len >= exp_len) pst = P_CRC;
          end
          P_CRC: begin
            rx_crc = b;
            pst = P_READY;
          end
          default: begin
            crc_run = '0;
            got_len = 0;
            pst = P_HDR0;
          end
        endcase
      end
      MODE_READ: begin
        rd = store[it.read_index];
        n_reads++;
      end
      MODE_RELEASE: begin
        if (pst == P_READY) pst = P_HDR0;
      end
      default: ;
    endcase
    if (!was_ready && pst == P_READY) begin
      n_packets++;
      if (rx_crc == crc_run) n_crc_ok++;
    end
    r.packet_ready = (pst == P_READY);
    r.packet_size = (pst == P_READY) ? got_len[10:0] : 11'd0;
    r.read_data = rd;
    r.crc_value = crc_run;
    r.crc_match = (pst == P_READY) && (rx_crc == crc_run);
  endtask

  // bursty sender: waits for acceptance, then records the expected result
  task automatic send_item(input cpd_in_t it, input bit zero_res);
    int unsigned gap;
    cpd_out_t    r;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (!in_ready);
    predict(it, r);
    exp_q.push_back(zero_res ? cpd_out_t'('0) : r);
    n_items++;
  endtask

  task automatic feed_byte(input logic [7:0] b);
    send_item(mk_item(MODE_RECV, b, 10'($urandom)), 1'b0);
  endtask

  // only entries already written since reset are read
  task automatic read_back();
    if (filled != 0)
      send_item(mk_item(MODE_READ, 8'($urandom), 10'($urandom_range(0, filled - 1))), 1'b0);
  endtask

  task automatic send_frame(input logic [15:0] len, input bit bad_crc);
    logic [7:0]  c, b;
    logic [7:0]  lead[4];
    int unsigned n;
    c = '0;
    lead[0] = hdr_a;
    lead[1] = hdr_b;
    lead[2] = len[15:8];
    lead[3] = len[7:0];
    foreach (lead[k]) begin
      c = crc_step(c, lead[k]);
      feed_byte(lead[k]);
    end
    n = (len == 0) ? 1 : len;
    repeat (n) begin
      b = 8'($urandom);
      c = crc_step(c, b);
      feed_byte(b);
      if ($urandom_range(0, 11) == 0) read_back();
    end
    feed_byte(bad_crc ? c ^ 8'($urandom_range(1, 255)) : c);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin : main
    int unsigned start, r, t, len;
    logic [7:0]  ha, hb;
    bit          hold_done;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= REG_HEADER_FIRST;
    cfg_data <= '0;
    rst_ni <= 1'b0;
    hold_done = 1'b0;
    hdr_a = HeaderFirstRst;
    hdr_b = HeaderSecondRst;
    pst = P_HDR0;
    crc_run = '0;
    exp_len = '0;
    got_len = 0;
    rx_crc = '0;
    filled = 0;
    n_settings = 1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[k])
      send_item(mk_item(dir_tab[k].mode, dir_tab[k].b, dir_tab[k].idx), dir_tab[k].zero_res);

    // one long frame so that reads spread over more buffer addresses
    send_frame(16'(LONG_FRAME_LEN), 1'b0);
    send_item(mk_item(MODE_RELEASE, 8'($urandom), 10'($urandom)), 1'b0);

    for (int p = 0; p < 5; p++) begin
      if (p != 0) begin
        drain();
        case (p)
          1: begin ha = 8'h00; hb = 8'hFF; end
          2: begin ha = 8'hFF; hb = 8'h00; end
          3: begin ha = 8'h3C; hb = 8'h3C; end
          default: begin ha = 8'($urandom); hb = 8'($urandom); end
        endcase
        cfg_we <= 1'b1;
        cfg_idx <= REG_HEADER_FIRST;
        cfg_data <= ha;
        @(posedge clk_i);
        hdr_a = ha;
        cfg_idx <= REG_HEADER_SECOND;
        cfg_data <= hb;
        @(posedge clk_i);
        hdr_b = hb;
        cfg_we <= 1'b0;
        n_settings++;
      end
      start = n_items;
      while (n_items - start < ITEMS_PER_SETTING) begin
        if (p == 2 && !hold_done && n_items - start >= 40) begin
          hold_req = 1'b1;
          hold_done = 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(0, 8);
          send_frame(16'(len), $urandom_range(0, 4) == 0);
          t = $urandom_range(0, 9);
          if (t < 2) repeat ($urandom_range(1, 3)) read_back();
          else if (t < 6) send_item(mk_item(MODE_RELEASE, 8'($urandom), 10'($urandom)), 1'b0);
          else if (t < 7) send_item(mk_item(MODE_UNUSED, 8'($urandom), 10'($urandom)), 1'b0);
          else if (t < 8) feed_byte(hdr_a ^ 8'($urandom_range(1, 255)));
          // otherwise the packet is left ready for the items that follow
        end else if (r < 65) begin
          repeat ($urandom_range(1, 3)) read_back();
        end else if (r < 72) begin
          send_item(mk_item($urandom_range(0, 1) ? MODE_RELEASE : MODE_UNUSED,
                            8'($urandom), 10'($urandom)), 1'b0);
        end else if (r < 84) begin
          repeat ($urandom_range(1, 4)) feed_byte(8'($urandom));
        end else begin
          case ($urandom_range(0, 3))
            0: begin
              feed_byte(hdr_a);
              feed_byte(hdr_b ^ 8'($urandom_range(1, 255)));
            end
            1: begin
              feed_byte(hdr_a);
              feed_byte(hdr_b);
              feed_byte(8'($urandom_range(4, 255)));
              feed_byte(8'($urandom));
            end
            2: begin
              len = $urandom_range(2, 6);
              feed_byte(hdr_a);
              feed_byte(hdr_b);
              feed_byte(8'h00);
              feed_byte(8'(len));
              repeat ($urandom_range(1, len - 1)) feed_byte(8'($urandom));
            end
            default: begin
              feed_byte(hdr_a);
              if ($urandom_range(0, 1) != 0) feed_byte(hdr_b);
            end
          endcase
        end
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("Run covered %0d items under %0d header settings: %0d packets completed,",
             n_items, n_settings, n_packets);
    $display("%0d with a matching check byte, %0d buffer reads, %0d results compared.",
             n_crc_ok, n_reads, n_results);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin : receiver
    int unsigned run;
    bit          lvl;
    out_ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          lvl = 1'b1;
          run = $urandom_range(30, 60);
        end else begin
          lvl = ($urandom_range(0, 2) != 0);
          run = $urandom_range(1, 5);
        end
        out_ready <= lvl;
        repeat (run) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : scoreboard
    cpd_out_t    w, g;
    logic [10:0] ev[5], gv[5];
    if (rst_ni && out_valid && out_ready) begin
      g = out_item;
      n_results++;
      if (exp_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result %h arrived with nothing expected", $time, g);
      end else begin
        w = exp_q.pop_front();
        ev = '{w.packet_ready, w.packet_size, w.read_data, w.crc_value, w.crc_match};
        gv = '{g.packet_ready, g.packet_size, g.read_data, g.crc_value, g.crc_match};
        for (int k = 0; k < 5; k++) begin
          if (gv[k] !== ev[k]) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: %s expected %0d got %0d", $time, fname[k], ev[k], gv[k]);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule
